// File: design/sphc_pkg.sv
// Shared types, codes and helpers for the stepper position and homing controller.
// Used by the channel interfaces and the top level; no dependencies.
package sphc_pkg;

  localparam int POS_BITS     = 24;
  localparam int STEP_BITS    = POS_BITS + 1;
  localparam int HT_BITS      = 16;
  localparam int MOVED_BITS   = 4;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DAT_BITS = POS_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_TRAVEL = 1'b1;

  localparam logic [HT_BITS-1:0] HOME_TRAVEL_RST = 16'd200;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_SET_TARGET   = 3'd1,
    OP_ADD_STEPS    = 3'd2,
    OP_START_HOME   = 3'd3,
    OP_SET_UPPER    = 3'd4,
    OP_CHECK_BOUNDS = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_STOP      = 2'd1,
    CMD_MOVE      = 2'd2,
    CMD_STOP_MOVE = 2'd3
  } motor_cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_HOME_BUSY   = 3'd1,
    ERR_OUT_BOUNDS  = 3'd2,
    ERR_NO_LIMIT    = 3'd3,
    ERR_LIMIT_STUCK = 3'd4,
    ERR_MOVED_OUT   = 3'd5
  } error_e;

  // Controller mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_MOVE     = 4'b0010,
    MODE_HOME_TO  = 4'b0100,
    MODE_HOME_OFF = 4'b1000
  } mode_e;

  localparam logic [1:0] STATE_IDLE     = 2'd0;
  localparam logic [1:0] STATE_MOVE     = 2'd1;
  localparam logic [1:0] STATE_HOME_TO  = 2'd2;
  localparam logic [1:0] STATE_HOME_OFF = 2'd3;

  // Encode the one-hot mode as the reported two-bit state
  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:     c = STATE_IDLE;
      MODE_MOVE:     c = STATE_MOVE;
      MODE_HOME_TO:  c = STATE_HOME_TO;
      MODE_HOME_OFF: c = STATE_HOME_OFF;
      default:       c = STATE_IDLE;
    endcase
    return c;
  endfunction

  // Clamp a widened sum into the signed position range
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [POS_BITS+1:0] v);
    logic signed [POS_BITS+1:0] hi;
    logic signed [POS_BITS+1:0] lo;
    logic signed [POS_BITS+1:0] r;
    hi = {3'b000, {(POS_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[POS_BITS-1:0];
  endfunction

endpackage

// File: design/sphc_if.sv
// Valid/ready channel interfaces: command items in, result items out, config writes.
// Depends on sphc_pkg for field widths.
interface sphc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            opcode;
  logic signed [sphc_pkg::POS_BITS-1:0]  value;
  logic                                  limit_triggered;
  logic                                  stepper_moving;
  logic signed [sphc_pkg::MOVED_BITS-1:0] moved_steps;

  modport source(output valid, opcode, value, limit_triggered, stepper_moving, moved_steps,
                 input ready);
  modport sink(input valid, opcode, value, limit_triggered, stepper_moving, moved_steps,
               output ready);
endinterface

interface sphc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            motor_cmd;
  logic                                  motor_run;
  logic signed [sphc_pkg::STEP_BITS-1:0] move_steps;
  logic                                  slow_speed;
  logic [2:0]                            error_code;
  logic                                  home_done;
  logic                                  home_ok;
  logic [1:0]                            ctl_state;
  logic signed [sphc_pkg::POS_BITS-1:0]  current_position;
  logic signed [sphc_pkg::POS_BITS-1:0]  target_position;

  modport source(output valid, motor_cmd, motor_run, move_steps, slow_speed, error_code,
                 home_done, home_ok, ctl_state, current_position, target_position,
                 input ready);
  modport sink(input valid, motor_cmd, motor_run, move_steps, slow_speed, error_code,
               home_done, home_ok, ctl_state, current_position, target_position,
               output ready);
endinterface

interface sphc_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [sphc_pkg::CFG_IDX_BITS-1:0]       index;
  logic [sphc_pkg::CFG_DAT_BITS-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/stepper_position_homing_controller.sv
// Stepper axis supervisor: position tracking, target bounds and limit-switch homing.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the result side is ready; the single-pass update logic limits nothing further.
// Reset (rst_ni low, async): mode idle, positions and upper limit zero,
// lower_limit 0, home_travel 200, both pipeline registers empty.
// Depends on sphc_pkg and the channel interfaces in sphc_if.sv.
module stepper_position_homing_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  sphc_cfg_if.sink     cfg_i,
  sphc_in_if.sink      in_i,
  sphc_out_if.source   out_o
);

  localparam int P  = sphc_pkg::POS_BITS;
  localparam int S  = sphc_pkg::STEP_BITS;
  localparam int HB = sphc_pkg::HT_BITS;

  // Configuration registers
  logic signed [P-1:0] lower_limit_q;
  logic [HB-1:0]       home_travel_q;

  // Axis state
  sphc_pkg::mode_e     mode_q, mode_d;
  logic signed [P-1:0] actual_q, actual_d;
  logic signed [P-1:0] goal_q, goal_d;
  logic signed [P-1:0] top_q, top_d;

  // Input register
  logic                        in_vld_q;
  logic [2:0]                  op_q;
  logic signed [P-1:0]         val_q;
  logic                        lim_q;
  logic                        mov_q;
  logic signed [sphc_pkg::MOVED_BITS-1:0] moved_q;

  // Result register
  logic                out_vld_q;
  logic [1:0]          cmd_q, cmd_d;
  logic                run_q, run_d;
  logic signed [S-1:0] steps_q, steps_d;
  logic                slow_q, slow_d;
  logic [2:0]          err_q, err_d;
  logic                done_q, done_d;
  logic                ok_q, ok_d;

  logic advance;
  logic in_take;

  // Advance the input register into the result register whenever the result slot
  // is empty or being drained this cycle.
  assign advance       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready    = !in_vld_q || advance;
  assign in_take       = in_i.valid && in_i.ready;
  assign cfg_i.ready   = 1'b1;

  // Configuration writes; the user must issue them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_limit_q <= '0;
      home_travel_q <= sphc_pkg::HOME_TRAVEL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sphc_pkg::CFG_LOWER_LIMIT: lower_limit_q <= cfg_i.data[P-1:0];
        sphc_pkg::CFG_HOME_TRAVEL: home_travel_q <= cfg_i.data[HB-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the item until it advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= in_i.opcode;
      val_q   <= in_i.value;
      lim_q   <= in_i.limit_triggered;
      mov_q   <= in_i.stepper_moving;
      moved_q <= in_i.moved_steps;
    end
  end

  // Single-pass update of the axis state for the item in the input register.
  always_comb begin
    logic signed [P:0]   tgt;
    logic signed [P:0]   lo_w;
    logic signed [P:0]   top_w;
    logic signed [P:0]   shift;
    logic signed [S-1:0] ht_w;
    logic                homing;

    lo_w   = {lower_limit_q[P-1], lower_limit_q};
    top_w  = {top_q[P-1], top_q};
    ht_w   = {{(S-HB){1'b0}}, home_travel_q};
    homing = (mode_q == sphc_pkg::MODE_HOME_TO) || (mode_q == sphc_pkg::MODE_HOME_OFF);
    // Exact target: a set takes the value, an add checks the unsaturated sum.
    if (op_q == sphc_pkg::OP_SET_TARGET) begin
      tgt = {val_q[P-1], val_q};
    end else begin
      tgt = {goal_q[P-1], goal_q} + {val_q[P-1], val_q};
    end
    shift = {val_q[P-1], val_q} - top_w;

    mode_d   = mode_q;
    actual_d = actual_q;
    goal_d   = goal_q;
    top_d    = top_q;
    cmd_d    = sphc_pkg::CMD_NONE;
    run_d    = 1'b0;
    steps_d  = '0;
    slow_d   = 1'b0;
    err_d    = sphc_pkg::ERR_NONE;
    done_d   = 1'b0;
    ok_d     = 1'b0;

    case (op_q)
      sphc_pkg::OP_SET_TARGET, sphc_pkg::OP_ADD_STEPS: begin
        if (homing) begin
          err_d = sphc_pkg::ERR_HOME_BUSY;
        end else if (tgt > top_w || tgt < lo_w) begin
          err_d = sphc_pkg::ERR_OUT_BOUNDS;
        end else begin
          mode_d  = sphc_pkg::MODE_MOVE;
          goal_d  = tgt[P-1:0];
          steps_d = tgt - {actual_q[P-1], actual_q};
          cmd_d   = sphc_pkg::CMD_MOVE;
        end
      end
      sphc_pkg::OP_START_HOME: begin
        if (homing) begin
          err_d  = sphc_pkg::ERR_HOME_BUSY;
          done_d = 1'b1;
        end else begin
          mode_d  = sphc_pkg::MODE_HOME_TO;
          cmd_d   = sphc_pkg::CMD_STOP_MOVE;
          slow_d  = 1'b1;
          steps_d = ht_w;
        end
      end
      sphc_pkg::OP_SET_UPPER: begin
        // Move the upper limit and shift both positions with it, saturating.
        top_d    = val_q;
        actual_d = sphc_pkg::sat_pos({{2{actual_q[P-1]}}, actual_q} + {shift[P], shift});
        goal_d   = sphc_pkg::sat_pos({{2{goal_q[P-1]}}, goal_q} + {shift[P], shift});
      end
      sphc_pkg::OP_CHECK_BOUNDS: begin
        if (actual_q > top_q || actual_q < lower_limit_q || lim_q) begin
          err_d = sphc_pkg::ERR_MOVED_OUT;
          cmd_d = sphc_pkg::CMD_STOP;
        end
      end
      sphc_pkg::OP_TICK: begin
        case (mode_q)
          sphc_pkg::MODE_MOVE: begin
            run_d    = 1'b1;
            actual_d = sphc_pkg::sat_pos({{2{actual_q[P-1]}}, actual_q}
                                         + {{(P+2-sphc_pkg::MOVED_BITS){moved_q[3]}}, moved_q});
            if (!mov_q) begin
              mode_d = sphc_pkg::MODE_IDLE;
            end
          end
          sphc_pkg::MODE_HOME_TO: begin
            if (!lim_q) begin
              if (mov_q) begin
                run_d = 1'b1;
              end else begin
                err_d  = sphc_pkg::ERR_NO_LIMIT;
                mode_d = sphc_pkg::MODE_IDLE;
                done_d = 1'b1;
              end
            end else begin
              // Switch found: back off it at slow speed.
              cmd_d   = sphc_pkg::CMD_STOP_MOVE;
              slow_d  = 1'b1;
              steps_d = -ht_w;
              mode_d  = sphc_pkg::MODE_HOME_OFF;
            end
          end
          sphc_pkg::MODE_HOME_OFF: begin
            if (lim_q) begin
              if (mov_q) begin
                run_d = 1'b1;
              end else begin
                err_d  = sphc_pkg::ERR_LIMIT_STUCK;
                mode_d = sphc_pkg::MODE_IDLE;
                done_d = 1'b1;
              end
            end else begin
              // Switch left: the axis sits at the upper limit; head for zero, or stop if zero is out of bounds.
              actual_d = top_q;
              done_d   = 1'b1;
              ok_d     = 1'b1;
              if (top_q[P-1] || lower_limit_q > 0) begin
                goal_d = top_q;
                mode_d = sphc_pkg::MODE_IDLE;
                err_d  = sphc_pkg::ERR_OUT_BOUNDS;
                cmd_d  = sphc_pkg::CMD_STOP;
              end else begin
                goal_d  = '0;
                mode_d  = sphc_pkg::MODE_MOVE;
                steps_d = -{top_q[P-1], top_q};
                cmd_d   = sphc_pkg::CMD_STOP_MOVE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State update, committed as the item advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sphc_pkg::MODE_IDLE;
      actual_q <= '0;
      goal_q   <= '0;
      top_q    <= '0;
    end else if (advance) begin
      mode_q   <= mode_d;
      actual_q <= actual_d;
      goal_q   <= goal_d;
      top_q    <= top_d;
    end
  end

  // Result register: valid holds until the sink takes the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q   <= cmd_d;
      run_q   <= run_d;
      steps_q <= steps_d;
      slow_q  <= slow_d;
      err_q   <= err_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
    end
  end

  // Positions and state are reported as left by the item; the state registers
  // already hold that while no newer item has advanced, so keep copies.
  logic signed [P-1:0] cur_pos_q;
  logic signed [P-1:0] tgt_pos_q;
  logic [1:0]          state_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cur_pos_q <= actual_d;
      tgt_pos_q <= goal_d;
      state_q   <= sphc_pkg::mode_code(mode_d);
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.motor_cmd        = cmd_q;
  assign out_o.motor_run        = run_q;
  assign out_o.move_steps       = steps_q;
  assign out_o.slow_speed       = slow_q;
  assign out_o.error_code       = err_q;
  assign out_o.home_done        = done_q;
  assign out_o.home_ok          = ok_q;
  assign out_o.ctl_state        = state_q;
  assign out_o.current_position = cur_pos_q;
  assign out_o.target_position  = tgt_pos_q;

endmodule

// File: tb/axis_monitor.sv
// Result checker for the stepper axis supervisor: mirrors the axis state, works out the
// report for every accepted command item and compares it with the block's result items.
// Depends on sphc_pkg and the channel interfaces in sphc_if.sv.
module axis_monitor
  import sphc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sphc_cfg_if  cfg_i,
  sphc_in_if   cmd_i,
  sphc_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   homed_o
);

  typedef struct {
    logic [1:0]                  cmd;
    logic                        run;
    logic signed [STEP_BITS-1:0] steps;
    logic                        slow;
    logic [2:0]                  err;
    logic                        done;
    logic                        ok;
    logic [1:0]                  state;
    logic signed [POS_BITS-1:0]  cur;
    logic signed [POS_BITS-1:0]  tgt;
  } axis_report_t;

  longint       lower_lim = 0;
  longint       travel    = HOME_TRAVEL_RST;
  longint       top_lim   = 0;
  longint       act_pos   = 0;
  longint       goal_pos  = 0;
  logic [1:0]   axis_mode = STATE_IDLE;
  axis_report_t due_reports[$];
  int           fail_cnt  = 0;
  int           due_cnt   = 0;
  int           seen_cnt  = 0;
  int           homed_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = due_cnt;
  assign checked_o    = seen_cnt;
  assign homed_o      = homed_cnt;

  function automatic longint clamp_pos(longint v);
    longint hi;
    hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Apply one command item to the mirrored state and return the report it causes.
  function automatic axis_report_t advance_axis(logic [2:0] op, longint val, logic lim,
                                                logic moving, longint moved);
    axis_report_t r;
    longint       t;
    longint       d;
    longint       steps;
    logic         homing;
    r.cmd  = CMD_NONE;
    r.run  = 1'b0;
    r.slow = 1'b0;
    r.err  = ERR_NONE;
    r.done = 1'b0;
    r.ok   = 1'b0;
    steps  = 0;
    homing = (axis_mode == STATE_HOME_TO) || (axis_mode == STATE_HOME_OFF);
    case (op)
      OP_SET_TARGET, OP_ADD_STEPS: begin
        // the add is bounds-checked on the exact sum, before any clamping
        t = (op == OP_SET_TARGET) ? val : goal_pos + val;
        if (homing) begin
          r.err = ERR_HOME_BUSY;
        end else if (t > top_lim || t < lower_lim) begin
          r.err = ERR_OUT_BOUNDS;
        end else begin
          axis_mode = STATE_MOVE;
          goal_pos  = t;
          steps     = goal_pos - act_pos;
          r.cmd     = CMD_MOVE;
        end
      end
      OP_START_HOME: begin
        if (homing) begin
          r.err  = ERR_HOME_BUSY;
          r.done = 1'b1;
        end else begin
          axis_mode = STATE_HOME_TO;
          r.cmd     = CMD_STOP_MOVE;
          r.slow    = 1'b1;
          steps     = travel;
        end
      end
      OP_SET_UPPER: begin
        d        = val - top_lim;
        top_lim  = val;
        act_pos  = clamp_pos(act_pos + d);
        goal_pos = clamp_pos(goal_pos + d);
      end
      OP_CHECK_BOUNDS: begin
        if (act_pos > top_lim || act_pos < lower_lim || lim) begin
          r.err = ERR_MOVED_OUT;
          r.cmd = CMD_STOP;
        end
      end
      OP_TICK: begin
        case (axis_mode)
          STATE_MOVE: begin
            r.run   = 1'b1;
            act_pos = clamp_pos(act_pos + moved);
            if (!moving) axis_mode = STATE_IDLE;
          end
          STATE_HOME_TO: begin
            if (lim) begin
              r.cmd     = CMD_STOP_MOVE;
              r.slow    = 1'b1;
              steps     = -travel;
              axis_mode = STATE_HOME_OFF;
            end else if (moving) begin
              r.run = 1'b1;
            end else begin
              r.err     = ERR_NO_LIMIT;
              r.done    = 1'b1;
              axis_mode = STATE_IDLE;
            end
          end
          STATE_HOME_OFF: begin
            if (lim && moving) begin
              r.run = 1'b1;
            end else if (lim) begin
              r.err     = ERR_LIMIT_STUCK;
              r.done    = 1'b1;
              axis_mode = STATE_IDLE;
            end else begin
              // switch left: both positions snap to the upper limit, then head for zero unless it is out of bounds
              act_pos   = top_lim;
              goal_pos  = top_lim;
              axis_mode = STATE_IDLE;
              r.done    = 1'b1;
              r.ok      = 1'b1;
              if (top_lim < 0 || lower_lim > 0) begin
                r.err = ERR_OUT_BOUNDS;
                r.cmd = CMD_STOP;
              end else begin
                axis_mode = STATE_MOVE;
                goal_pos  = 0;
                steps     = -act_pos;
                r.cmd     = CMD_STOP_MOVE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.steps = steps[STEP_BITS-1:0];
    r.state = axis_mode;
    r.cur   = act_pos[POS_BITS-1:0];
    r.tgt   = goal_pos[POS_BITS-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s wrong on result %0d: expected %0d, got %0d",
               $time, name, seen_cnt, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    axis_report_t want;
    if (!rst_ni) begin
      lower_lim = 0;
      travel    = HOME_TRAVEL_RST;
      top_lim   = 0;
      act_pos   = 0;
      goal_pos  = 0;
      axis_mode = STATE_IDLE;
      due_reports.delete();
      due_cnt   = 0;
    end else begin
      // retire the result before queuing a new command: the block never turns an item
      // around within the edge that accepts it
      if (res_i.valid && res_i.ready) begin
        if (due_reports.size() == 0) begin
          fail_cnt++;
          $display("%0t: result item with none expected: state %0d, position %0d",
                   $time, res_i.ctl_state, res_i.current_position);
        end else begin
          want = due_reports.pop_front();
          check_field("motor_cmd", want.cmd, res_i.motor_cmd);
          check_field("motor_run", want.run, res_i.motor_run);
          check_field("move_steps", want.steps, res_i.move_steps);
          check_field("slow_speed", want.slow, res_i.slow_speed);
          check_field("error_code", want.err, res_i.error_code);
          check_field("home_done", want.done, res_i.home_done);
          check_field("home_ok", want.ok, res_i.home_ok);
          check_field("ctl_state", want.state, res_i.ctl_state);
          check_field("current_position", want.cur, res_i.current_position);
          check_field("target_position", want.tgt, res_i.target_position);
          if (want.done) homed_cnt++;
          seen_cnt++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_LOWER_LIMIT: lower_lim = longint'($signed(cfg_i.data));
          CFG_HOME_TRAVEL: travel = cfg_i.data[HT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready)
        due_reports.push_back(advance_axis(cmd_i.opcode, cmd_i.value, cmd_i.limit_triggered,
                                           cmd_i.stepper_moving, cmd_i.moved_steps));
      due_cnt = due_reports.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the stepper axis supervisor: clock, reset, command and register
// stimulus, result-side back-pressure and the verdict. Depends on sphc_pkg, sphc_if.sv,
// the block itself and the axis_monitor checker.
module tb_top;
  import sphc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_ITEMS     = 190;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     pending;
  int     checked;
  int     homed;
  int     sent_items     = 0;
  int     settings_used  = 0;
  int     send_idle_pct  = 0;
  int     recv_idle_pct  = 0;
  int     cycles         = 0;
  logic   hold_off_req   = 1'b0;
  logic   hold_off_taken = 1'b0;
  // what the stimulus knows of the limits, used to aim targets inside them
  longint lower_hint     = 0;
  longint top_hint       = 0;

  sphc_cfg_if reg_wr ();
  sphc_in_if  cmd_ch ();
  sphc_out_if res_ch ();

  stepper_position_homing_controller u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (reg_wr),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  axis_monitor u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (reg_wr),
    .cmd_i        (cmd_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .homed_o      (homed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if it hangs anywhere.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: drop ready at random, and once hold it low for a long stretch so the
  // block fills up and pushes back on the command channel.
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        res_ch.ready   = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic longint rand_pos();
    logic [31:0]                r;
    logic signed [POS_BITS-1:0] v;
    r = $urandom();
    v = r[POS_BITS-1:0];
    return v;
  endfunction

  function automatic logic rand_bit();
    logic [31:0] r;
    r = $urandom();
    return r[0];
  endfunction

  function automatic int rand_moved();
    return int'($urandom_range(14)) - 7;
  endfunction

  // Offer one command item at the falling edge and hold it until it is accepted.
  // Valid stays high on return; idle gaps or the next item decide what follows.
  task automatic send_cmd(logic [2:0] op, longint val, logic lim, logic moving, int moved);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid           = 1'b1;
    cmd_ch.opcode          = op;
    cmd_ch.value           = val[POS_BITS-1:0];
    cmd_ch.limit_triggered = lim;
    cmd_ch.stepper_moving  = moving;
    cmd_ch.moved_steps     = moved[MOVED_BITS-1:0];
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint wdata);
    reg_wr.valid = 1'b1;
    reg_wr.index = idx;
    reg_wr.data  = wdata[CFG_DAT_BITS-1:0];
    @(posedge clk);
    while (!reg_wr.ready) @(posedge clk);
    @(negedge clk);
    reg_wr.valid = 1'b0;
  endtask

  task automatic tick(logic lim, logic moving);
    send_cmd(OP_TICK, rand_pos(), lim, moving, rand_moved());
  endtask

  // One random burst: mostly well-formed moves and homing runs, the rest noise.
  task automatic random_burst();
    int          pick;
    longint      lo;
    longint      t;
    logic [31:0] any_op;
    pick = $urandom_range(99);
    if (pick < 35) begin
      lo = (lower_hint > top_hint - 4000) ? lower_hint : top_hint - 4000;
      if (lo <= top_hint) t = lo + $urandom_range(int'(top_hint - lo));
      else t = rand_pos();
      // now and then aim just outside the window
      if ($urandom_range(9) == 0) t = top_hint + 1 + $urandom_range(20);
      if ($urandom_range(9) == 0) t = lower_hint - 1 - $urandom_range(20);
      if ($urandom_range(2) == 0)
        send_cmd(OP_ADD_STEPS, int'($urandom_range(600)) - 300, rand_bit(), rand_bit(), 0);
      else
        send_cmd(OP_SET_TARGET, t, rand_bit(), rand_bit(), rand_moved());
      repeat ($urandom_range(6)) tick(rand_bit(), 1'b1);
      tick(rand_bit(), 1'b0);
    end else if (pick < 58) begin
      send_cmd(OP_START_HOME, rand_pos(), rand_bit(), rand_bit(), rand_moved());
      if ($urandom_range(7) == 0) send_cmd(OP_SET_TARGET, 0, 1'b0, 1'b0, 0);
      if ($urandom_range(7) == 0) send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
      repeat ($urandom_range(5)) tick(1'b0, 1'b1);
      if ($urandom_range(9) == 0) begin
        tick(1'b0, 1'b0);
      end else begin
        tick(1'b1, rand_bit());
        repeat ($urandom_range(5)) tick(1'b1, 1'b1);
        if ($urandom_range(9) == 0) begin
          tick(1'b1, 1'b0);
        end else begin
          tick(1'b0, rand_bit());
          repeat ($urandom_range(4)) tick(rand_bit(), 1'b1);
          tick(rand_bit(), 1'b0);
        end
      end
    end else if (pick < 68) begin
      if ($urandom_range(19) == 0) t = rand_pos();
      else t = int'($urandom_range(9000)) - 3000;
      top_hint = t;
      send_cmd(OP_SET_UPPER, t, rand_bit(), rand_bit(), rand_moved());
    end else if (pick < 78) begin
      send_cmd(OP_CHECK_BOUNDS, rand_pos(), rand_bit(), rand_bit(), rand_moved());
    end else begin
      any_op = $urandom_range(7);
      send_cmd(any_op[2:0], rand_pos(), rand_bit(), rand_bit(), rand_moved());
    end
  endtask

  // Wait until every result is back, reprogram both registers, then run random bursts.
  task automatic run_phase(longint lower, longint travel, int sidle, int ridle, int count,
                           bit squeeze);
    int stop_at;
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(CFG_LOWER_LIMIT, lower);
    write_reg(CFG_HOME_TRAVEL, travel);
    lower_hint    = lower;
    settings_used++;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    stop_at       = sent_items + count;
    while (sent_items < stop_at) begin
      if (squeeze && sent_items >= stop_at - count / 2) hold_off_req = 1'b1;
      random_burst();
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    reg_wr.valid           = 1'b0;
    reg_wr.index           = CFG_LOWER_LIMIT;
    reg_wr.data            = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.opcode          = OP_TICK;
    cmd_ch.value           = '0;
    cmd_ch.limit_triggered = 1'b0;
    cmd_ch.stepper_moving  = 1'b0;
    cmd_ch.moved_steps     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, on the reset register values.
    send_idle_pct = 9;
    recv_idle_pct = 9;
    send_cmd(OP_SET_UPPER, 1000, 1'b0, 1'b0, 0);
    send_cmd(OP_SET_TARGET, 500, 1'b0, 1'b0, 0);
    tick(1'b0, 1'b1);
    send_cmd(OP_TICK, 0, 1'b0, 1'b0, -7);
    send_cmd(OP_SET_TARGET, 1001, 1'b0, 1'b0, 0);
    send_cmd(OP_SET_TARGET, -1, 1'b0, 1'b0, 0);
    send_cmd(OP_ADD_STEPS, 8388607, 1'b0, 1'b0, 0);
    send_cmd(OP_ADD_STEPS, 200, 1'b0, 1'b0, 7);
    send_cmd(OP_CHECK_BOUNDS, 0, 1'b1, 1'b0, 0);
    // homing that succeeds, with busy rejections in both homing modes
    send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
    send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
    tick(1'b0, 1'b1);
    tick(1'b1, 1'b1);
    send_cmd(OP_ADD_STEPS, 5, 1'b1, 1'b1, 0);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    // homing that never finds the switch, then one that never leaves it
    send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
    tick(1'b0, 1'b0);
    send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    send_cmd(3'd6, -1, 1'b1, 1'b1, -1);
    send_cmd(3'd7, -1, 1'b1, 1'b1, -1);
    // upper limit extremes clamp both positions; homing then ends with zero out of bounds
    send_cmd(OP_SET_UPPER, 8388607, 1'b0, 1'b0, 0);
    send_cmd(OP_SET_UPPER, -8388608, 1'b0, 1'b0, 0);
    send_cmd(OP_START_HOME, 0, 1'b0, 1'b0, 0);
    tick(1'b1, 1'b1);
    tick(1'b0, 1'b0);
    // move at the top of the range and overshoot it
    send_cmd(OP_SET_UPPER, 8388607, 1'b0, 1'b0, 0);
    send_cmd(OP_SET_TARGET, 8388607, 1'b0, 1'b0, 0);
    send_cmd(OP_TICK, 0, 1'b0, 1'b0, 7);
    top_hint = 8388607;

    // Random part over several register settings; the first runs without any idling.
    run_phase(-8388608, 65535, 0, 0, PHASE_ITEMS, 1'b0);
    run_phase(-500, 1, 9, 9, PHASE_ITEMS, 1'b1);
    run_phase(8388607, 37, 9, 9, PHASE_ITEMS / 2, 1'b0);
    run_phase(-longint'($urandom_range(2000)), 1 + $urandom_range(65534), 9, 9,
              PHASE_ITEMS, 1'b0);
    run_phase(0, 200, 9, 9, PHASE_ITEMS, 1'b0);

    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d command items over %0d register settings and one long result stall.",
             sent_items, settings_used);
    $display("Compared %0d result items; %0d of them closed a homing request.", checked, homed);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
